/* rtl/core/iira_pkg.sv */
// package for the indexed insert/remove array list
// holds field widths, command and status codes, controller/datapath bundles
// and the double-compare helper; no dependencies
package iira_pkg;

    // default number of list entries
    localparam int CAPACITY_DFLT = 64;

    // fixed field widths of the channels
    localparam int CMD_W = 3;
    localparam int POS_W = 7;
    localparam int VAL_W = 64;
    localparam int ST_W  = 2;
    localparam int HIT_W = 6;
    localparam int LEN_W = 7;

    // ieee double pattern constants
    localparam logic [VAL_W-2:0] EXP_ONES = 63'h7FF0_0000_0000_0000;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_GET    = 3'd2,
        CMD_FIND   = 3'd3,
        CMD_CLEAR  = 3'd4
    } t_cmd;

    // result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    // memory read address source
    typedef enum logic [1:0] {
        RD_PTR     = 2'd0,
        RD_PTR_DEC = 2'd1,
        RD_PTR_INC = 2'd2,
        RD_POS     = 2'd3
    } t_rd_sel;

    // memory write address and data source
    typedef enum logic {
        WR_SHIFT = 1'b0,
        WR_NEW   = 1'b1
    } t_wr_sel;

    // walk pointer update
    typedef enum logic [2:0] {
        PTR_HOLD  = 3'd0,
        PTR_COUNT = 3'd1,
        PTR_POS   = 3'd2,
        PTR_ZERO  = 3'd3,
        PTR_INC   = 3'd4,
        PTR_DEC   = 3'd5
    } t_ptr_op;

    // entry count update
    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_INC  = 2'd1,
        CNT_DEC  = 2'd2,
        CNT_CLR  = 2'd3
    } t_cnt_op;

    // controller to datapath commands
    typedef struct packed {
        logic    capture;
        t_ptr_op ptr_op;
        t_cnt_op cnt_op;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    res_set;
        t_status res_status;
        logic    res_hit;
        logic    res_get;
        logic    deliver;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        t_cmd cmd;
        logic ins_range;
        logic full;
        logic pos_range;
        logic up_more;
        logic dn_more;
        logic find_more;
        logic match;
        logic out_free;
    } t_dp_stat;

    // nan test on a double pattern
    function automatic logic f_is_nan(input logic [VAL_W-1:0] x);
        return x[VAL_W-2:0] > EXP_ONES;
    endfunction

    // ieee equality: +0 equals -0, nan equals nothing
    function automatic logic f_dbl_eq(input logic [VAL_W-1:0] a,
                                      input logic [VAL_W-1:0] b);
        logic both_zero;
        both_zero = (a[VAL_W-2:0] == '0) && (b[VAL_W-2:0] == '0);
        if (f_is_nan(a) || f_is_nan(b)) begin
            return 1'b0;
        end
        return both_zero || (a == b);
    endfunction

endpackage

/* rtl/core/iira_if.sv */
// channel interfaces for the indexed insert/remove array list
// command channel and result channel; depends on iira_pkg

// command channel
interface iira_in_if;
    import iira_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value_in;

    modport source (output valid, output cmd, output position, output value_in,
                    input ready);
    modport sink   (input valid, input cmd, input position, input value_in,
                    output ready);
endinterface

// result channel
interface iira_out_if;
    import iira_pkg::*;

    logic             valid;
    logic             ready;
    logic [ST_W-1:0]  status;
    logic [VAL_W-1:0] value_out;
    logic [HIT_W-1:0] found_position;
    logic [LEN_W-1:0] length;

    modport source (output valid, output status, output value_out,
                    output found_position, output length, input ready);
    modport sink   (input valid, input status, input value_out,
                    input found_position, input length, output ready);
endinterface

/* rtl/core/iira_ctrl.sv */
// controller for the indexed insert/remove array list
// one-hot sequencer issuing datapath commands; depends on iira_pkg
module iira_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  iira_pkg::t_dp_stat i_stat,
    output iira_pkg::t_dp_cmd  o_cmd
);
    import iira_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b0_0000_0001,
        S_DECODE   = 9'b0_0000_0010,
        S_UP_RD    = 9'b0_0000_0100,
        S_UP_WR    = 9'b0_0000_1000,
        S_DN_RD    = 9'b0_0001_0000,
        S_DN_WR    = 9'b0_0010_0000,
        S_FIND_RD  = 9'b0_0100_0000,
        S_FIND_CHK = 9'b0_1000_0000,
        S_DONE     = 9'b1_0000_0000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd w_cmd;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and command decode
    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state       = S_DONE;
                w_cmd.res_set = 1'b1;
                case (i_stat.cmd)
                    CMD_INSERT: begin
                        if (i_stat.ins_range) begin
                            w_cmd.res_status = ST_RANGE;
                        end else if (i_stat.full) begin
                            w_cmd.res_status = ST_FULL;
                        end else begin
                            w_cmd.res_set = 1'b0;
                            w_cmd.ptr_op  = PTR_COUNT;
                            n_state       = S_UP_RD;
                        end
                    end
                    CMD_REMOVE: begin
                        if (i_stat.pos_range) begin
                            w_cmd.res_status = ST_RANGE;
                        end else begin
                            w_cmd.res_set = 1'b0;
                            w_cmd.ptr_op  = PTR_POS;
                            n_state       = S_DN_RD;
                        end
                    end
                    CMD_GET: begin
                        if (i_stat.pos_range) begin
                            w_cmd.res_status = ST_RANGE;
                        end else begin
                            w_cmd.res_status = ST_OK;
                            w_cmd.res_get    = 1'b1;
                            w_cmd.rd_en      = 1'b1;
                            w_cmd.rd_sel     = RD_POS;
                        end
                    end
                    CMD_FIND: begin
                        w_cmd.res_set = 1'b0;
                        w_cmd.ptr_op  = PTR_ZERO;
                        n_state       = S_FIND_RD;
                    end
                    CMD_CLEAR: begin
                        w_cmd.res_status = ST_OK;
                        w_cmd.cnt_op     = CNT_CLR;
                    end
                    default: begin
                        w_cmd.res_status = ST_OK;
                    end
                endcase
            end
            // shift up from the top, then place the new word
            S_UP_RD: begin
                if (i_stat.up_more) begin
                    w_cmd.rd_en  = 1'b1;
                    w_cmd.rd_sel = RD_PTR_DEC;
                    n_state      = S_UP_WR;
                end else begin
                    w_cmd.wr_en      = 1'b1;
                    w_cmd.wr_sel     = WR_NEW;
                    w_cmd.cnt_op     = CNT_INC;
                    w_cmd.res_set    = 1'b1;
                    w_cmd.res_status = ST_OK;
                    n_state          = S_DONE;
                end
            end
            S_UP_WR: begin
                w_cmd.wr_en  = 1'b1;
                w_cmd.wr_sel = WR_SHIFT;
                w_cmd.ptr_op = PTR_DEC;
                n_state      = S_UP_RD;
            end
            // shift down from the removed slot
            S_DN_RD: begin
                if (i_stat.dn_more) begin
                    w_cmd.rd_en  = 1'b1;
                    w_cmd.rd_sel = RD_PTR_INC;
                    n_state      = S_DN_WR;
                end else begin
                    w_cmd.cnt_op     = CNT_DEC;
                    w_cmd.res_set    = 1'b1;
                    w_cmd.res_status = ST_OK;
                    n_state          = S_DONE;
                end
            end
            S_DN_WR: begin
                w_cmd.wr_en  = 1'b1;
                w_cmd.wr_sel = WR_SHIFT;
                w_cmd.ptr_op = PTR_INC;
                n_state      = S_DN_RD;
            end
            // linear scan from index zero
            S_FIND_RD: begin
                if (i_stat.find_more) begin
                    w_cmd.rd_en  = 1'b1;
                    w_cmd.rd_sel = RD_PTR;
                    n_state      = S_FIND_CHK;
                end else begin
                    w_cmd.res_set    = 1'b1;
                    w_cmd.res_status = ST_MISSING;
                    n_state          = S_DONE;
                end
            end
            S_FIND_CHK: begin
                if (i_stat.match) begin
                    w_cmd.res_set    = 1'b1;
                    w_cmd.res_status = ST_OK;
                    w_cmd.res_hit    = 1'b1;
                    n_state          = S_DONE;
                end else begin
                    w_cmd.ptr_op = PTR_INC;
                    n_state      = S_FIND_RD;
                end
            end
            // hand the result to the output register once it is free
            S_DONE: begin
                if (i_stat.out_free) begin
                    w_cmd.deliver = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd      = w_cmd;
    assign o_in_ready = (r_state == S_IDLE);

endmodule

/* rtl/core/iira_dp.sv */
// datapath for the indexed insert/remove array list
// entry memory, count, walk pointer and result register; depends on iira_pkg
module iira_dp #(
    parameter int CAPACITY = iira_pkg::CAPACITY_DFLT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [iira_pkg::CMD_W-1:0]   i_cmd,
    input  logic [iira_pkg::POS_W-1:0]   i_position,
    input  logic [iira_pkg::VAL_W-1:0]   i_value_in,
    input  iira_pkg::t_dp_cmd            i_dp_cmd,
    output iira_pkg::t_dp_stat           o_stat,
    iira_out_if.source                   o_out
);
    import iira_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    // entry storage, no reset
    logic [VAL_W-1:0] r_mem [CAPACITY];
    logic [VAL_W-1:0] r_rd_q;

    // captured transaction
    logic [CMD_W-1:0] r_cmd;
    logic [POS_W-1:0] r_pos;
    logic [VAL_W-1:0] r_val;

    // list state and walk pointer
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] r_ptr;
    logic [CW-1:0] n_ptr;

    // pending result
    t_status          r_res_status;
    logic [HIT_W-1:0] r_res_hit;
    logic             r_res_get;

    // output register
    logic             r_out_valid;
    t_status          r_o_status;
    logic [VAL_W-1:0] r_o_value;
    logic [HIT_W-1:0] r_o_hit;
    logic [LEN_W-1:0] r_o_len;

    logic [XW-1:0] w_pos_x;
    logic [XW-1:0] w_cnt_x;
    logic [XW-1:0] w_ptr_x;
    logic [CW-1:0] w_ptr_dec;
    logic [CW-1:0] w_ptr_inc;
    logic [AW-1:0] w_rd_addr;
    logic [AW-1:0] w_wr_addr;
    logic [VAL_W-1:0] w_wr_data;

    assign w_pos_x   = XW'(r_pos);
    assign w_cnt_x   = XW'(r_count);
    assign w_ptr_x   = XW'(r_ptr);
    assign w_ptr_dec = r_ptr - CW'(1);
    assign w_ptr_inc = r_ptr + CW'(1);

    // capture the command fields
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.capture) begin
            r_cmd <= i_cmd;
            r_pos <= i_position;
            r_val <= i_value_in;
        end
    end

    // read address select
    always_comb begin
        case (i_dp_cmd.rd_sel)
            RD_PTR:     w_rd_addr = r_ptr[AW-1:0];
            RD_PTR_DEC: w_rd_addr = w_ptr_dec[AW-1:0];
            RD_PTR_INC: w_rd_addr = w_ptr_inc[AW-1:0];
            RD_POS:     w_rd_addr = w_pos_x[AW-1:0];
            default:    w_rd_addr = r_ptr[AW-1:0];
        endcase
    end

    // write address and data select
    always_comb begin
        case (i_dp_cmd.wr_sel)
            WR_NEW: begin
                w_wr_addr = w_pos_x[AW-1:0];
                w_wr_data = r_val;
            end
            default: begin
                w_wr_addr = r_ptr[AW-1:0];
                w_wr_data = r_rd_q;
            end
        endcase
    end

    // entry memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_dp_cmd.rd_en) begin
            r_rd_q <= r_mem[w_rd_addr];
        end
    end

    // pointer and count updates
    always_comb begin
        case (i_dp_cmd.ptr_op)
            PTR_COUNT: n_ptr = r_count;
            PTR_POS:   n_ptr = w_pos_x[CW-1:0];
            PTR_ZERO:  n_ptr = '0;
            PTR_INC:   n_ptr = w_ptr_inc;
            PTR_DEC:   n_ptr = w_ptr_dec;
            default:   n_ptr = r_ptr;
        endcase
        case (i_dp_cmd.cnt_op)
            CNT_INC: n_count = r_count + CW'(1);
            CNT_DEC: n_count = r_count - CW'(1);
            CNT_CLR: n_count = '0;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ptr   <= '0;
        end else begin
            r_count <= n_count;
            r_ptr   <= n_ptr;
        end
    end

    // pending result
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.res_set) begin
            r_res_status <= i_dp_cmd.res_status;
            r_res_hit    <= i_dp_cmd.res_hit ? w_ptr_x[HIT_W-1:0] : '0;
            r_res_get    <= i_dp_cmd.res_get;
        end
    end

    // output register and its valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_dp_cmd.deliver) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.deliver) begin
            r_o_status <= r_res_status;
            r_o_value  <= r_res_get ? r_rd_q : '0;
            r_o_hit    <= r_res_hit;
            r_o_len    <= w_cnt_x[LEN_W-1:0];
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_o_status;
    assign o_out.value_out      = r_o_value;
    assign o_out.found_position = r_o_hit;
    assign o_out.length         = r_o_len;

    // status toward the controller
    assign o_stat.cmd       = t_cmd'(r_cmd);
    assign o_stat.ins_range = w_pos_x > w_cnt_x;
    assign o_stat.full      = (r_count == CW'(CAPACITY));
    assign o_stat.pos_range = w_pos_x >= w_cnt_x;
    assign o_stat.up_more   = w_ptr_x > w_pos_x;
    assign o_stat.dn_more   = (XW'(w_ptr_inc) < w_cnt_x);
    assign o_stat.find_more = w_ptr_x < w_cnt_x;
    assign o_stat.match     = f_dbl_eq(r_rd_q, r_val);
    assign o_stat.out_free  = !r_out_valid || o_out.ready;

    // count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // a new word is placed only when there is room
    a_put_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_dp_cmd.wr_en && i_dp_cmd.wr_sel == WR_NEW) |-> (r_count < CW'(CAPACITY)))
        else $error("insert into full list");

    // a result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dp_cmd.deliver |-> (!r_out_valid || o_out.ready))
        else $error("result overwritten");

    // count moves by one step or drops to zero
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_count != $past(r_count)) |->
        (r_count == $past(r_count) + CW'(1) || r_count == $past(r_count) - CW'(1)
         || r_count == '0))
        else $error("count jumped");

endmodule

/* rtl/core/indexed_insert_remove_array.sv */
// Ordered list of up to CAPACITY 64-bit words with insert, remove, get, find
// (IEEE double equality) and clear. Work runs through one entry memory with a
// single write and a single registered read per cycle; shifts and searches
// handle each word with a read state followed by a write or compare state.
// Insert shifts the entries from index p upward before placing the new word,
// remove moves the entries above index p down, and find scans from index
// zero. One transaction is in work at a time; a finished result waits in an
// output register while the next transaction is accepted. No clearing pass
// after reset. Depends on iira_pkg, iira_if, iira_ctrl and iira_dp.
module indexed_insert_remove_array #(
    parameter int CAPACITY = iira_pkg::CAPACITY_DFLT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    iira_in_if.sink    i_in,
    iira_out_if.source o_out
);
    import iira_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;

    assign i_in.ready = w_in_ready;

    // sequencer
    iira_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // storage and result path
    iira_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (i_in.cmd),
        .i_position (i_in.position),
        .i_value_in (i_in.value_in),
        .i_dp_cmd   (w_cmd),
        .o_stat     (w_stat),
        .o_out      (o_out)
    );

endmodule
